// ===== hdl/usbaa_pkg.sv =====
// ----------------------------------------------------------------------------
// usbaa_pkg
// shared types, constants and helpers of the usb device address allocator
// ----------------------------------------------------------------------------
package usbaa_pkg;

    localparam int ADDRESS_COUNT = 128;
    localparam int ADDR_W        = $clog2(ADDRESS_COUNT);

    typedef logic [ADDR_W-1:0] addr_t;

    // last grant after reset, so the first grant is the top address
    localparam addr_t LAST_RESET = addr_t'(ADDRESS_COUNT - 2);
    localparam addr_t ADDR_TOP   = addr_t'(ADDRESS_COUNT - 1);
    localparam addr_t ADDR_FIRST = addr_t'(1);
    localparam addr_t ADDR_NONE  = addr_t'(0);

    // request kinds
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } ctl_state_t;

    // controller to datapath
    typedef struct packed {
        logic start_scan;
        logic release_wr;
        logic scan_rd;
        logic take_fail;
        logic take_grant;
        logic commit;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit_free;
        logic hit_last;
        logic out_busy;
    } dp_stat_t;

    // next candidate, wrapping and skipping the default address
    function automatic addr_t next_addr(input addr_t a);
        addr_t n;
        n = (a == ADDR_TOP) ? ADDR_FIRST : addr_t'(a + addr_t'(1));
        return n;
    endfunction

endpackage

// ===== hdl/usbaa_ctrl.sv =====
// ----------------------------------------------------------------------------
// usbaa_ctrl
// sequencing of release, scan and result hand-off
// ----------------------------------------------------------------------------
module usbaa_ctrl
    import usbaa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_op,
    output logic     in_ready,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_op == OP_RELEASE)
                    begin
                        cmd.release_wr = 1'b1;
                        state_next     = ST_RESP;
                    end
                    else
                    begin
                        cmd.start_scan = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // priority: the wrap back to the last grant ends the scan
                priority if (stat.hit_last)
                begin
                    cmd.take_fail = 1'b1;
                    state_next    = ST_RESP;
                end
                else if (stat.hit_free)
                begin
                    cmd.take_grant = 1'b1;
                    state_next     = ST_RESP;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                end
            end
            ST_RESP:
            begin
                if (!stat.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/usbaa_dpath.sv =====
// ----------------------------------------------------------------------------
// usbaa_dpath
// occupancy map, scan pointer, last grant and result register
// ----------------------------------------------------------------------------
module usbaa_dpath
    import usbaa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ctl_cmd_t cmd,
    output dp_stat_t stat,
    input  addr_t    rel_addr,
    input  logic     out_ready,
    output logic     out_valid,
    output logic     out_status,
    output addr_t    out_addr
);

    // occupancy bits; an entry never written reads as free
    logic                     map_mem [ADDRESS_COUNT];
    logic [ADDRESS_COUNT-1:0] map_vld_reg;

    addr_t last_reg;
    addr_t cand_reg;
    addr_t rd_addr_reg;
    logic  rd_vld_reg;
    logic  rd_mem_reg;
    logic  rd_bit_vld_reg;

    logic  res_status_reg;
    addr_t res_addr_reg;
    logic  res_grant_reg;

    logic  out_valid_reg;
    logic  out_status_reg;
    addr_t out_addr_reg;

    logic  wr_en;
    logic  wr_data;
    addr_t wr_addr;
    logic  rd_occ;

    assign wr_en   = cmd.release_wr || (cmd.commit && res_grant_reg);
    assign wr_data = !cmd.release_wr;
    assign wr_addr = cmd.release_wr ? rel_addr : res_addr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (cmd.scan_rd)
        begin
            rd_mem_reg <= map_mem[cand_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_vld_reg    <= '0;
            rd_bit_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                map_vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd.scan_rd)
            begin
                rd_bit_vld_reg <= map_vld_reg[cand_reg];
            end
        end
    end

    assign rd_occ = rd_bit_vld_reg && rd_mem_reg;

    // scan pointer and read tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg    <= ADDR_NONE;
            rd_addr_reg <= ADDR_NONE;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_rd;
            if (cmd.start_scan)
            begin
                cand_reg <= next_addr(last_reg);
            end
            else if (cmd.scan_rd)
            begin
                cand_reg    <= next_addr(cand_reg);
                rd_addr_reg <= cand_reg;
            end
        end
    end

    assign stat.hit_last = rd_vld_reg && (rd_addr_reg == last_reg);
    assign stat.hit_free = rd_vld_reg && (rd_addr_reg != last_reg) && !rd_occ;
    assign stat.out_busy = out_valid_reg && !out_ready;

    // pending result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_grant_reg <= 1'b0;
        end
        else if (cmd.release_wr || cmd.take_fail)
        begin
            res_grant_reg <= 1'b0;
        end
        else if (cmd.take_grant)
        begin
            res_grant_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.release_wr)
        begin
            res_status_reg <= STATUS_OK;
            res_addr_reg   <= ADDR_NONE;
        end
        else if (cmd.take_fail)
        begin
            res_status_reg <= STATUS_NO_SPACE;
            res_addr_reg   <= ADDR_NONE;
        end
        else if (cmd.take_grant)
        begin
            res_status_reg <= STATUS_OK;
            res_addr_reg   <= rd_addr_reg;
        end
    end

    // last grant and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= LAST_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit && res_grant_reg)
            begin
                last_reg <= res_addr_reg;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_addr   = out_addr_reg;

    a_grant_not_default: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && res_grant_reg) |-> (res_addr_reg != ADDR_NONE))
        else $error("grant of the default address");

    a_hit_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.hit_free && stat.hit_last))
        else $error("scan hit both free and last grant");

    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && !out_ready))
        else $error("result overwrote a pending result");

    a_grant_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && res_grant_reg) |=> (map_vld_reg[last_reg] && last_reg != ADDR_NONE))
        else $error("granted address not recorded");

endmodule

// ===== hdl/usb_address_allocator.sv =====
// ----------------------------------------------------------------------------
// usb_address_allocator
// round-robin usb device address allocator over a 128-entry occupancy map
// ----------------------------------------------------------------------------
// Each request on the slave stream gives exactly one result on the master
// stream. An allocate request scans the occupancy map forward from the
// address after the last grant, wrapping and skipping the default address 0,
// and grants the first free address; reaching the last granted address again
// returns no-space, so that address is never offered twice in a row. A
// release clears the mark of the given address and returns success with
// address 0. The map is read through a single registered port, one address
// per cycle, so an allocate lasts longer the more addresses it examines; a
// release needs no scan.
// One request is in work at a time; a new one is taken as soon as the
// previous result sits in the output register, even before it is consumed.
// After reset the map is empty and the first grant is address 127.
module usb_address_allocator
    import usbaa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // request stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [6:0] release_addr, [7] zero pad
    input  logic       s_axis_tuser,   // [0] op: 0 allocate, 1 release
    // result stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] granted_addr, [7] zero pad
    output logic       m_axis_tuser    // [0] status: 0 ok, 1 no space
);

    ctl_cmd_t cmd;
    dp_stat_t stat;
    logic     ctl_ready;
    addr_t    out_addr;

    usbaa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (ctl_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    usbaa_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .rel_addr   (s_axis_tdata[ADDR_W-1:0]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_status (m_axis_tuser),
        .out_addr   (out_addr)
    );

    // request accepted only in idle; results go out from the output register
    assign s_axis_tready = ctl_ready;
    assign m_axis_tdata  = {{(8 - ADDR_W){1'b0}}, out_addr};

endmodule

// ===== tb/usb_address_allocator_test.sv =====
// ----------------------------------------------------------------------------
// usb_address_allocator_test
// self-checking stream testbench for the usb device address allocator
// ----------------------------------------------------------------------------
// Requests go in on the slave stream and results come back on the master
// stream. Every accepted request is run through a local model of the
// occupancy map and the last grant. The result that the model predicts is
// queued and compared with the next result that the block returns.
// The run has three parts. A short directed opening comes first. Then come
// fill and drain passes that reach the no-space case and the rule that the
// last grant is not handed out again. Random traffic follows. Both sides
// insert random gaps, and the gap rates change from one phase to the next.
// ----------------------------------------------------------------------------
module usb_address_allocator_test
    import usbaa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no handshake on either stream before the run is abandoned
    localparam int STALL_LIMIT = 4000;
    // quiet cycles after the last result, a full map scan plus margin
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic  status;
        addr_t granted;
    } alloc_result_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [6:0] release_addr, [7] zero pad
    logic       s_axis_tuser  = 1'b0;    // [0] op
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [6:0] granted_addr, [7] zero pad
    logic       m_axis_tuser;            // [0] status

    // model state: which addresses are handed out, and the last grant
    logic [ADDRESS_COUNT-1:0] held_map;
    addr_t                    last_grant;

    alloc_result_t pending_results[$];
    int            mismatch_count = 0;
    int            send_gap_pct   = 0;
    int            recv_stall_pct = 0;
    int            quiet_cycles   = 0;

    usb_address_allocator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // model of the allocator
    // ------------------------------------------------------------------

    // applies one request to the model and returns the result it should give
    function automatic alloc_result_t predict_response(input logic op, input addr_t addr);
        alloc_result_t res;
        addr_t         cand;
        bit            done;
        res.status  = STATUS_OK;
        res.granted = ADDR_NONE;
        if (op == OP_RELEASE)
        begin
            // releasing address 0 or a free address leaves the map as it was
            held_map[addr] = 1'b0;
            return res;
        end
        res.status = STATUS_NO_SPACE;
        cand       = last_grant;
        done       = 1'b0;
        for (int step = 0; step < ADDRESS_COUNT && !done; step++)
        begin
            // walk forward, wrapping from the top address to 1, never 0
            cand = (cand == ADDR_TOP) ? ADDR_FIRST : addr_t'(cand + 1'b1);
            if (cand == last_grant)
                done = 1'b1;   // back at the last grant: no space, even if it is free
            else if (!held_map[cand])
            begin
                held_map[cand] = 1'b1;
                last_grant     = cand;
                res.status     = STATUS_OK;
                res.granted    = cand;
                done           = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic int held_count();
        int n;
        n = 0;
        for (int a = 1; a < ADDRESS_COUNT; a++)
            n += held_map[a];
        return n;
    endfunction

    // random address that the model holds as granted, caller checks count
    function automatic addr_t pick_held();
        addr_t q[$];
        for (int a = 1; a < ADDRESS_COUNT; a++)
            if (held_map[a])
                q.push_back(addr_t'(a));
        return q[$urandom_range(q.size() - 1)];
    endfunction

    function automatic addr_t any_addr();
        return addr_t'($urandom_range(ADDRESS_COUNT - 1));
    endfunction

    // ------------------------------------------------------------------
    // stimulus and checking
    // ------------------------------------------------------------------

    // one request on the slave stream, with random gaps before it
    task automatic send_request(input logic op, input addr_t addr);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, addr};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(predict_response(op, addr));
    endtask

    // result side back-pressure, redrawn each cycle
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin : result_check
        alloc_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no request pending, status %0d addr %0d",
                         $time, m_axis_tuser, m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d got %0d",
                             $time, want.status, m_axis_tuser);
                    mismatch_count++;
                end
                if (m_axis_tdata !== {1'b0, want.granted})
                begin
                    $display("%0t: granted_addr mismatch, expected %0d got %0d",
                             $time, {1'b0, want.granted}, m_axis_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: no handshake on either stream for too long ends the run
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("** usb_address_allocator: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // opening sequence from reset: top address first, wrap past 0, releases
    task automatic test_directed_cases();
        send_request(OP_ALLOC,   ADDR_NONE);            // first grant is the top address
        send_request(OP_ALLOC,   ADDR_TOP);             // wraps to 1, skipping address 0
        send_request(OP_ALLOC,   addr_t'(7'h55));       // 2
        send_request(OP_RELEASE, ADDR_NONE);            // release of address 0
        send_request(OP_RELEASE, addr_t'(7'h55));       // release of a free address
        send_request(OP_RELEASE, ADDR_TOP);             // release of the top address
        send_request(OP_ALLOC,   addr_t'(7'h2a));       // 3
        send_request(OP_RELEASE, addr_t'(7'h2a));       // free address again
        send_request(OP_RELEASE, addr_t'(3));           // last grant released
        send_request(OP_ALLOC,   ADDR_NONE);            // scan starts past it, gives 4
        send_request(OP_RELEASE, ADDR_FIRST);
        send_request(OP_RELEASE, addr_t'(2));
        send_request(OP_RELEASE, addr_t'(4));           // map empty again
        send_request(OP_ALLOC,   ADDR_TOP);             // 5
        send_request(OP_ALLOC,   ADDR_NONE);            // 6
        send_request(OP_RELEASE, addr_t'(6));
        send_request(OP_RELEASE, addr_t'(5));
        send_request(OP_RELEASE, ADDR_TOP);             // top address already free
    endtask

    // fill the whole map, hit no-space and the last-grant rule, then drain
    task automatic test_fill_to_exhaustion();
        addr_t held_last;
        addr_t other;
        int    guard;
        guard = 0;
        // mostly allocates, with a few stray releases mixed in
        while (held_count() < ADDRESS_COUNT - 1 && guard < 600)
        begin
            if ($urandom_range(9) == 0)
                send_request(OP_RELEASE, any_addr());
            else
                send_request(OP_ALLOC, any_addr());
            guard++;
        end
        send_request(OP_ALLOC, any_addr());       // full map: no space
        held_last = last_grant;
        send_request(OP_RELEASE, held_last);
        send_request(OP_ALLOC, any_addr());       // only free slot is the last grant: refused
        other = addr_t'($urandom_range(ADDRESS_COUNT - 1, 1));
        while (other == held_last)
            other = addr_t'($urandom_range(ADDRESS_COUNT - 1, 1));
        send_request(OP_RELEASE, other);
        send_request(OP_ALLOC, any_addr());       // takes the other slot
        send_request(OP_ALLOC, any_addr());       // old last grant is offered again
        send_request(OP_ALLOC, any_addr());       // full again
        // drain in random order with some noise
        guard = 0;
        while (held_count() > 0 && guard < 600)
        begin
            case ($urandom_range(19))
                0, 1:    send_request(OP_ALLOC, any_addr());
                2:       send_request(OP_RELEASE, any_addr());
                default: send_request(OP_RELEASE, pick_held());
            endcase
            guard++;
        end
    endtask

    // random mix; alloc_pct sets how hard the map is pushed toward full
    task automatic test_random_traffic(input int item_count, input int alloc_pct);
        for (int i = 0; i < item_count; i++)
        begin
            if ($urandom_range(99) < alloc_pct)
                send_request(OP_ALLOC, any_addr());
            else if (held_count() > 0 && $urandom_range(99) < 80)
                send_request(OP_RELEASE, pick_held());
            else
                send_request(OP_RELEASE, any_addr());
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        held_map   = '0;
        last_grant = LAST_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // phase 1: sender gaps rare, receiver stalls often
        send_gap_pct   = 10;
        recv_stall_pct = 69;
        test_directed_cases();
        test_fill_to_exhaustion();
        test_random_traffic(350, 55);

        // phase 2: sender gaps often, receiver stalls rare
        send_gap_pct   = 69;
        recv_stall_pct = 10;
        test_fill_to_exhaustion();
        test_random_traffic(360, 70);

        // phase 3: back to back on both sides
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_fill_to_exhaustion();
        test_random_traffic(360, 50);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // any stray result in this window is caught by the checker
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("** usb_address_allocator: PASSED **");
        else
            $display("** usb_address_allocator: FAILED **");
        $finish;
    end

endmodule
